// ===== src/nfsa_pkg.sv =====
// Package for the next-fit slot allocator.
// Holds sizes, action codes and the step unit's operation and result types.
// No dependencies.
package nfsa_pkg;

	localparam int SLOTS = 16;
	localparam int IDX_W = 4;
	localparam int CNT_W = 5;

	localparam logic [CNT_W-1:0] ACTIVE_RESET = CNT_W'(SLOTS);

	localparam logic ACTION_ALLOC   = 1'b0;
	localparam logic ACTION_RELEASE = 1'b1;

	typedef enum logic {
		OP_WRAP,
		OP_ADVANCE
	} step_op_t;

	typedef struct packed {
		logic             ge;
		logic [IDX_W-1:0] value;
	} step_res_t;

endpackage

// ===== src/next_fit_slot_allocator_unit.sv =====
// Top level of the next-fit slot allocator: active count register and sequencer.
// Depends on nfsa_pkg and nfsa_ctrl.
//
// A release presents its result word in the cycle after acceptance. An allocate first checks
// the start position and reduces it by the count while it is stale (up to 15 reductions after
// the count has shrunk), then probes slots with the shared step unit, up to the active count
// (at most 16 probes); its result word appears in the cycle after the last probe.
// The block takes one word at a time and holds its input stalled until the result word has
// been taken; it accepts the next word in the cycle after that. The active count is clamped to 1..16.
module next_fit_slot_allocator_unit import nfsa_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [CNT_W-1:0] cfg_wr_data,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             action,
	input  logic [IDX_W-1:0] slot_index,
	output logic             out_valid,
	input  logic             out_stall,
	output logic             ok,
	output logic [IDX_W-1:0] granted_slot
);

	logic [CNT_W-1:0] active_slots_q;
	logic [CNT_W-1:0] count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_slots_q <= ACTIVE_RESET;
		end else if (cfg_wr_en) begin
			active_slots_q <= cfg_wr_data;
		end
	end

	always_comb begin
		if (active_slots_q == '0) begin
			count = CNT_W'(1);
		end else if (active_slots_q > CNT_W'(SLOTS)) begin
			count = CNT_W'(SLOTS);
		end else begin
			count = active_slots_q;
		end
	end

	nfsa_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.count        (count),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.slot_index   (slot_index),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.ok           (ok),
		.granted_slot (granted_slot)
	);

endmodule

// ===== src/nfsa_step_unit.sv =====
// Shared step unit of the next-fit slot allocator.
// Reduces a stale position by the count, or advances a position with wrap.
// Depends on nfsa_pkg.
module nfsa_step_unit import nfsa_pkg::*; (
	input  step_op_t         op,
	input  logic [IDX_W-1:0] pos,
	input  logic [CNT_W-1:0] count,
	output step_res_t        res
);

	logic [CNT_W-1:0] pos_ext;
	logic [CNT_W-1:0] diff;
	logic [CNT_W-1:0] incr;

	assign pos_ext = {1'b0, pos};
	assign diff    = pos_ext - count;
	assign incr    = pos_ext + CNT_W'(1);

	always_comb begin
		res.ge = (pos_ext >= count);
		case (op)
			OP_WRAP: begin
				res.value = res.ge ? diff[IDX_W-1:0] : pos;
			end
			OP_ADVANCE: begin
				res.value = (incr == count) ? '0 : incr[IDX_W-1:0];
			end
			default: begin
				res.value = pos;
			end
		endcase
	end

endmodule

// ===== src/nfsa_ctrl.sv =====
// Sequencer of the next-fit slot allocator.
// Holds the free map, the last granted slot, the search state and the result word.
// Depends on nfsa_pkg and nfsa_step_unit.
module nfsa_ctrl import nfsa_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [CNT_W-1:0] count,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             action,
	input  logic [IDX_W-1:0] slot_index,
	output logic             out_valid,
	input  logic             out_stall,
	output logic             ok,
	output logic [IDX_W-1:0] granted_slot
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WRAP,
		ST_SEARCH,
		ST_DONE
	} state_t;

	state_t           state_q;
	logic [SLOTS-1:0] free_map_q;
	logic [IDX_W-1:0] last_given_q;
	logic [IDX_W-1:0] pos_q;
	logic [CNT_W-1:0] probes_q;
	logic             out_valid_q;
	logic             ok_q;
	logic [IDX_W-1:0] granted_q;

	step_op_t         op;
	step_res_t        res;
	logic             accept;

	assign op       = (state_q == ST_WRAP) ? OP_WRAP : OP_ADVANCE;
	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;

	assign out_valid    = out_valid_q;
	assign ok           = ok_q;
	assign granted_slot = granted_q;

	nfsa_step_unit u_step (
		.op    (op),
		.pos   (pos_q),
		.count (count),
		.res   (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			free_map_q   <= '1;
			last_given_q <= '0;
			pos_q        <= '0;
			probes_q     <= '0;
			out_valid_q  <= 1'b0;
			ok_q         <= 1'b0;
			granted_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (action == ACTION_RELEASE) begin
							granted_q   <= '0;
							out_valid_q <= 1'b1;
							state_q     <= ST_DONE;
							if ({1'b0, slot_index} < count) begin
								free_map_q[slot_index] <= 1'b1;
								ok_q                   <= 1'b1;
							end else begin
								ok_q <= 1'b0;
							end
						end else begin
							pos_q    <= last_given_q;
							probes_q <= '0;
							state_q  <= ST_WRAP;
						end
					end
				end
				ST_WRAP: begin
					// reduce a stale start position below the count
					pos_q <= res.value;
					if (!res.ge) begin
						state_q <= ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					pos_q <= res.value;
					if (free_map_q[res.value]) begin
						free_map_q[res.value] <= 1'b0;
						last_given_q          <= res.value;
						ok_q                  <= 1'b1;
						granted_q             <= res.value;
						out_valid_q           <= 1'b1;
						state_q               <= ST_DONE;
					end else if (probes_q == count - CNT_W'(1)) begin
						ok_q        <= 1'b0;
						granted_q   <= '0;
						out_valid_q <= 1'b1;
						state_q     <= ST_DONE;
					end else begin
						probes_q <= probes_q + CNT_W'(1);
					end
				end
				ST_DONE: begin
					// hold the result word until taken
					if (!out_stall) begin
						out_valid_q <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
